FILE: sv/tsrs_pkg.sv
// types and constants shared by the timestamp record sorter
// no dependencies
package tsrs_pkg;

  localparam int KEY_W = 24;
  localparam int TAG_W = 16;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;

  // contents of one sorting cell
  typedef struct packed {
    logic valid;
    key_t key;
    tag_t tag;
  } cell_data_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // a new item enters the chain
    logic shift;   // chain moves one place towards the head
  } cell_ctrl_t;

endpackage

FILE: sv/tsrs_if.sv
// valid/ready channel interfaces for the timestamp record sorter
// depends on tsrs_pkg
interface tsrs_in_if;
  logic          valid;
  logic          ready;
  tsrs_pkg::key_t time_ms;
  tsrs_pkg::tag_t line_tag;
  logic          last_item;

  modport source (output valid, time_ms, line_tag, last_item, input ready);
  modport sink   (input valid, time_ms, line_tag, last_item, output ready);
endinterface

interface tsrs_out_if;
  logic          valid;
  logic          ready;
  tsrs_pkg::key_t sorted_time_ms;
  tsrs_pkg::tag_t sorted_tag;
  logic          end_of_set;
  logic          overflowed;

  modport source (output valid, sorted_time_ms, sorted_tag, end_of_set, overflowed,
                  input ready);
  modport sink   (input valid, sorted_time_ms, sorted_tag, end_of_set, overflowed,
                  output ready);
endinterface

FILE: sv/tsrs_cell.sv
// one cell of the insertion sorting chain
// depends on tsrs_pkg
module tsrs_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsrs_pkg::cell_ctrl_t ctrl,
  input  tsrs_pkg::key_t       new_key,
  input  tsrs_pkg::tag_t       new_tag,
  input  tsrs_pkg::cell_data_t prev_data,
  input  logic                 prev_gb,
  input  tsrs_pkg::cell_data_t next_data,
  output tsrs_pkg::cell_data_t data,
  output logic                 gb
);
  import tsrs_pkg::*;

  cell_data_t data_r;
  cell_data_t data_nxt;

  // empty cell counts as larger than anything; equal keys keep load order
  assign gb = !data_r.valid || (data_r.key > new_key);

  // next contents: on insert take the left neighbour or the new item, on shift take the right neighbour
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = next_data;
    end else if (ctrl.insert && gb) begin
      if (prev_gb) begin
        data_nxt = prev_data;
      end else begin
        data_nxt.valid = 1'b1;
        data_nxt.key   = new_key;
        data_nxt.tag   = new_tag;
      end
    end
  end

  // cell register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else begin
      data_r.valid <= data_nxt.valid;
    end
    data_r.key <= data_nxt.key;
    data_r.tag <= data_nxt.tag;
  end

  assign data = data_r;

endmodule

FILE: sv/timestamp_record_sorter.sv
// the first result item is offered in the cycle after the item marked last is taken
// throughput: one input item per cycle while loading, one result item per cycle while emitting
// and out_ch.ready is high; no input is taken during emission
// the rate is set by the chain of cells, which either inserts an item or shifts one out
// reset (synchronous, active low) empties every cell and clears the overflow and emit flags
module timestamp_record_sorter #(
  parameter int MAX_RECORDS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  tsrs_in_if.sink    in_ch,
  tsrs_out_if.source out_ch
);
  import tsrs_pkg::*;

  cell_data_t             cell_data [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] cell_gb;
  logic [MAX_RECORDS-1:0] cell_valid;
  cell_ctrl_t             ctrl;

  logic emit_r,     emit_nxt;
  logic overflow_r, overflow_nxt;
  logic in_acc, out_acc, full, last_out;

  // handshakes
  assign in_ch.ready = !emit_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign full        = cell_valid[MAX_RECORDS-1];
  assign last_out    = !cell_valid[1];

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // chain of cells
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    cell_data_t prev_d;
    cell_data_t next_d;
    logic       prev_g;

    if (i == 0) begin : g_head
      assign prev_d = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
      assign prev_g = cell_gb[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_body
      assign next_d = cell_data[i+1];
    end

    tsrs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_key   (in_ch.time_ms),
      .new_tag   (in_ch.line_tag),
      .prev_data (prev_d),
      .prev_gb   (prev_g),
      .next_data (next_d),
      .data      (cell_data[i]),
      .gb        (cell_gb[i])
    );

    assign cell_valid[i] = cell_data[i].valid;
  end

  // emit and overflow flags
  always_comb begin
    emit_nxt     = emit_r;
    overflow_nxt = overflow_r;
    if (in_acc) begin
      if (full) begin
        overflow_nxt = 1'b1;
      end
      if (in_ch.last_item) begin
        emit_nxt = 1'b1;
      end
    end
    if (out_acc && last_out) begin
      emit_nxt     = 1'b0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r     <= 1'b0;
      overflow_r <= 1'b0;
    end else begin
      emit_r     <= emit_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // result item comes straight from the head cell
  assign out_ch.valid          = emit_r;
  assign out_ch.sorted_time_ms = cell_data[0].key;
  assign out_ch.sorted_tag     = cell_data[0].tag;
  assign out_ch.end_of_set     = last_out;
  assign out_ch.overflowed     = overflow_r;

  // head cell holds an item whenever a result is offered
  a_head_valid : assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> cell_valid[0])
    else $error("result offered from an empty head cell");

  // the item marked last always starts emission
  a_last_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.last_item |=> out_ch.valid)
    else $error("emission did not start after the last item");

  // the chain is empty and the overflow flag clear once the final result is taken
  a_drained : assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_ch.end_of_set |=> !cell_valid[0] && !overflow_r)
    else $error("chain not empty after end of set");

  // neighbouring occupied cells stay in ascending order, empties only at the tail
  for (genvar j = 0; j < MAX_RECORDS - 1; j++) begin : g_chk
    a_order : assert property (@(posedge clk) disable iff (!rst_n)
      cell_valid[j+1] |-> cell_valid[j] && (cell_data[j].key <= cell_data[j+1].key))
      else $error("sorting chain out of order");
  end

endmodule

FILE: sim/timestamp_record_sorter_check.sv
// watches both channels of the timestamp record sorter, predicts the sorted output
// and compares every result item field by field; depends on tsrs_pkg and tsrs_if
`timescale 1ns / 100ps

module timestamp_record_sorter_check #(
  parameter int MAX_RECORDS = 64
) (
  input  logic clk,
  input  logic rst_n,
  tsrs_in_if   in_ch,
  tsrs_out_if  out_ch,
  output int   mismatch_count,
  output int   results_due
);
  import tsrs_pkg::*;

  typedef struct packed {
    key_t key;
    tag_t tag;
    logic end_of_set;
    logic overflowed;
  } sorted_rec_t;

  // records of the open set, kept in ascending key order, ties in load order
  sorted_rec_t open_set[$];
  // sorted records still to come out of the block
  sorted_rec_t sorted_due[$];
  logic        set_dropped;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    set_dropped    = 1'b0;
  end

  // insert after every record whose key is not greater, so equal keys keep load order
  function automatic void file_record(key_t key, tag_t tag);
    sorted_rec_t rec;
    int          pos;
    rec = '{key: key, tag: tag, end_of_set: 1'b0, overflowed: 1'b0};
    pos = open_set.size();
    while (pos > 0 && open_set[pos-1].key > key) pos--;
    open_set.insert(pos, rec);
  endfunction

  // closing item: the whole open set becomes due, flags stamped on each record
  function automatic void close_set();
    sorted_rec_t rec;
    foreach (open_set[i]) begin
      rec            = open_set[i];
      rec.end_of_set = (i == open_set.size() - 1);
      rec.overflowed = set_dropped;
      sorted_due.push_back(rec);
    end
    open_set.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    sorted_rec_t want;
    if (!rst_n) begin
      open_set.delete();
      sorted_due.delete();
      set_dropped = 1'b0;
    end else begin
      // item taken on the input side
      if (in_ch.valid && in_ch.ready) begin
        if (open_set.size() < MAX_RECORDS) begin
          file_record(in_ch.time_ms, in_ch.line_tag);
        end else begin
          set_dropped = 1'b1;
        end
        if (in_ch.last_item) close_set();
      end
      // item taken on the result side
      if (out_ch.valid && out_ch.ready) begin
        if (sorted_due.size() == 0) begin
          $error("result item with none expected: sorted_time_ms %0d, sorted_tag %0d",
                 out_ch.sorted_time_ms, out_ch.sorted_tag);
          mismatch_count++;
        end else begin
          want = sorted_due.pop_front();
          check_field("sorted_time_ms", want.key, out_ch.sorted_time_ms);
          check_field("sorted_tag", want.tag, out_ch.sorted_tag);
          check_field("end_of_set", want.end_of_set, out_ch.end_of_set);
          check_field("overflowed", want.overflowed, out_ch.overflowed);
        end
      end
    end
    results_due = sorted_due.size();
  end

endmodule

FILE: sim/timestamp_record_sorter_test.sv
// top of the timestamp record sorter test: clock, reset, stimulus and verdict
// depends on tsrs_pkg, tsrs_if, timestamp_record_sorter and timestamp_record_sorter_check
`timescale 1ns / 100ps

module timestamp_record_sorter_test;
  import tsrs_pkg::*;

  localparam int MAX_RECORDS = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   results_due;
  int   items_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off_req = 1'b0;

  tsrs_in_if  in_ch ();
  tsrs_out_if out_ch ();

  timestamp_record_sorter #(
    .MAX_RECORDS(MAX_RECORDS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  timestamp_record_sorter_check #(
    .MAX_RECORDS(MAX_RECORDS)
  ) i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #5 clk = ~clk;

  // hard limit on the run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, or a long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // offer one record, with random idle cycles first, until it is taken
  task automatic offer_record(key_t key, tag_t tag, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.time_ms   <= key;
    in_ch.line_tag  <= tag;
    in_ch.last_item <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // a set of n records; a non-zero spread narrows the keys to force ties
  task automatic offer_set(int n, int unsigned spread);
    key_t key;
    for (int i = 0; i < n; i++) begin
      key = (spread == 0) ? key_t'($urandom) : key_t'($urandom_range(0, spread));
      offer_record(key, tag_t'($urandom), i == n - 1);
    end
  endtask

  // sender pauses until every sorted record has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // random sets, mostly small, now and then long enough to overflow
  task automatic random_sets(int item_goal);
    int          pick;
    int          n;
    int unsigned spread;
    while (items_sent < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) n = $urandom_range(1, 12);
      else if (pick < 95) n = $urandom_range(13, 40);
      else n = $urandom_range(MAX_RECORDS, MAX_RECORDS + 4);
      pick = $urandom_range(0, 99);
      if (pick < 50) spread = 0;
      else if (pick < 80) spread = 7;
      else spread = 16'hFFFF;
      offer_set(n, spread);
    end
  endtask

  initial begin
    key_t fall_keys [5];
    int   goal;
    fall_keys = '{24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h000001, 24'h000000};
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.time_ms   <= '0;
    in_ch.line_tag  <= '0;
    in_ch.last_item <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single-record sets at both key extremes
    offer_record(24'hFFFFFF, 16'hFFFF, 1'b1);
    offer_record(24'h000000, 16'h0000, 1'b1);
    // equal keys must keep load order
    for (int i = 0; i < 4; i++) offer_record(24'h001234, tag_t'(16'hA5A0 + i), i == 3);
    // falling keys across the top bit
    for (int i = 0; i < 5; i++) offer_record(fall_keys[i], tag_t'(16'h8000 >> i), i == 4);
    // interleaved ties
    for (int i = 0; i < 5; i++) offer_record(key_t'((i % 2) ? 3 : 5), tag_t'(i), i == 4);
    wait_drained();

    // long hold-off: the block takes a set, starts emitting and stalls its input
    hold_off_req = 1'b1;
    offer_set(40, 0);
    offer_set(8, 0);
    wait_drained();

    // full store exactly, then overflow with the closing record dropped, then more
    offer_set(MAX_RECORDS, 0);
    offer_set(MAX_RECORDS + 1, 3);
    offer_set(MAX_RECORDS + 6, 0);
    wait_drained();

    // random phases with different idling on each side
    goal = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      goal += 50;
      random_sets(goal);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tsrs_pkg.sv
sv/tsrs_if.sv
sv/tsrs_cell.sv
sv/timestamp_record_sorter.sv
sim/timestamp_record_sorter_check.sv
sim/timestamp_record_sorter_test.sv
